/* design/mwsg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform generator package
// Shared types, register indexes, default sizes and the sine table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package mwsg_pkg;

  // Default sizes
  localparam int unsigned PHASE_BITS      = 32;
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned SAMPLE_BITS     = 16;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_WAVEFORM    = 3'd0;
  localparam logic [2:0] REG_FREQ_STEP   = 3'd1;
  localparam logic [2:0] REG_PHASE_OFFS  = 3'd2;
  localparam logic [2:0] REG_AMPLITUDE   = 3'd3;
  localparam logic [2:0] REG_DC_OFFSET   = 3'd4;
  localparam logic [2:0] REG_OUTPUT_KIND = 3'd5;

  // Polynomial coefficients for sin(pi/2 * x), Q30
  localparam longint C_A1 = 64'sd1686629713;
  localparam longint C_A3 = 64'sd693598668;
  localparam longint C_A5 = 64'sd85569306;
  localparam longint C_A7 = 64'sd5026995;
  localparam longint C_A9 = 64'sd172272;

  typedef enum logic [1:0] {
    WAVE_SQUARE   = 2'd0,
    WAVE_SINE     = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAWTOOTH = 2'd3
  } wave_e;

  // Live configuration
  typedef struct packed {
    wave_e       waveform;
    logic [31:0] frequency_step;
    logic [31:0] phase_offset;
    logic [14:0] amplitude;
    logic [15:0] dc_offset;
    logic        output_unsigned;
  } cfg_t;

  // Phase stage result
  typedef struct packed {
    logic        valid;
    logic [31:0] turn;
    logic [31:0] phase;
  } ph_t;

  // Shape stage result
  typedef struct packed {
    logic               valid;
    logic               square;
    logic               negative;
    logic signed [16:0] shape;
    logic [31:0]        phase;
  } sh_t;

  // Quarter-wave sine entry k for a table indexed by the top stb bits of a turn
  function automatic logic [14:0] sine_entry(input int k, input int stb);
    longint x;
    longint x2;
    longint t;
    longint e;
    x  = longint'(k) <<< (32 - stb);
    x2 = (x * x) >>> 30;
    t  = C_A7 - ((x2 * C_A9) >>> 30);
    t  = C_A5 - ((x2 * t) >>> 30);
    t  = C_A3 - ((x2 * t) >>> 30);
    t  = C_A1 - ((x2 * t) >>> 30);
    t  = (x * t) >>> 30;
    e  = (t * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (e < 0) begin
      e = 0;
    end
    if (e > 32767) begin
      e = 32767;
    end
    return e[14:0];
  endfunction

endpackage

`default_nettype wire

/* design/multi_waveform_signal_generator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-waveform signal generator
// Phase-accumulator waveform source with square, sine, triangle and sawtooth.
// ----------------------------------------------------------------------------
// Each input transaction produces one output sample. The block takes one
// transaction per clock while the output is not stalled; phase, shape,
// scaling and saturation each have a register stage on the sample's path.
// The phase accumulator sits in a single-entry RAM and is rewritten on every
// accepted transaction; a forwarding register covers the read latency of the
// RAM, so the accumulator loop sets the rate at one sample per clock. The
// whole pipeline holds while the output transaction waits. Configuration must
// only be written while no sample is in flight.
`default_nettype none

module multi_waveform_signal_generator_top #(
  parameter int unsigned PhaseBits     = mwsg_pkg::PHASE_BITS,
  parameter int unsigned SineTableBits = mwsg_pkg::SINE_TABLE_BITS,
  parameter int unsigned SampleBits    = mwsg_pkg::SAMPLE_BITS,
  parameter int unsigned OutW          = ((SampleBits + 32 + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [0] restart
  // Output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [OutW-1:0]                 m_axis_tdata_o,  // sample, phase_now
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mwsg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import mwsg_pkg::*;

  cfg_t                  cfg;
  ph_t                   ph;
  sh_t                   sh;
  logic                  en;
  logic                  accept;
  logic                  out_valid;
  logic [SampleBits-1:0] sample;
  logic [31:0]           phase_now;

  // Advance the pipeline unless the output transaction is stalled
  assign en              = ~out_valid | m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i & en;

  mwsg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mwsg_phase #(
    .PhaseBits (PhaseBits)
  ) u_phase (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .accept_i         (accept),
    .restart_i        (s_axis_tdata_i[0]),
    .frequency_step_i (cfg.frequency_step),
    .phase_offset_i   (cfg.phase_offset),
    .ph_o             (ph)
  );

  mwsg_shape #(
    .SineTableBits (SineTableBits)
  ) u_shape (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .waveform_i (cfg.waveform),
    .ph_i       (ph),
    .sh_o       (sh)
  );

  mwsg_level #(
    .SampleBits (SampleBits)
  ) u_level (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .amplitude_i       (cfg.amplitude),
    .dc_offset_i       (cfg.dc_offset),
    .output_unsigned_i (cfg.output_unsigned),
    .sh_i              (sh),
    .valid_o           (out_valid),
    .sample_o          (sample),
    .phase_o           (phase_now)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = OutW'({phase_now, sample});

endmodule

`default_nettype wire

/* design/mwsg_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/mwsg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register block holding waveform, phase and level settings.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mwsg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output mwsg_pkg::cfg_t                  cfg_o
);

  import mwsg_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  // Write the addressed register, drop writes beyond the map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.waveform        <= WAVE_SINE;
      cfg_q.frequency_step  <= '0;
      cfg_q.phase_offset    <= '0;
      cfg_q.amplitude       <= 15'd16384;
      cfg_q.dc_offset       <= '0;
      cfg_q.output_unsigned <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WAVEFORM:    cfg_q.waveform        <= wave_e'(pwdata[1:0]);
        REG_FREQ_STEP:   cfg_q.frequency_step  <= pwdata;
        REG_PHASE_OFFS:  cfg_q.phase_offset    <= pwdata;
        REG_AMPLITUDE:   cfg_q.amplitude       <= pwdata[14:0];
        REG_DC_OFFSET:   cfg_q.dc_offset       <= pwdata[15:0];
        REG_OUTPUT_KIND: cfg_q.output_unsigned <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_WAVEFORM:    prdata = {30'd0, cfg_q.waveform};
      REG_FREQ_STEP:   prdata = cfg_q.frequency_step;
      REG_PHASE_OFFS:  prdata = cfg_q.phase_offset;
      REG_AMPLITUDE:   prdata = {17'd0, cfg_q.amplitude};
      REG_DC_OFFSET:   prdata = {16'd0, cfg_q.dc_offset};
      REG_OUTPUT_KIND: prdata = {31'd0, cfg_q.output_unsigned};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* design/mwsg_phase.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase accumulator
// Read-modify-write of the accumulator held in RAM, with write forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsg_phase #(
  parameter int unsigned PhaseBits = mwsg_pkg::PHASE_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            accept_i,
  input  logic            restart_i,
  input  logic [31:0]     frequency_step_i,
  input  logic [31:0]     phase_offset_i,
  output mwsg_pkg::ph_t   ph_o
);

  import mwsg_pkg::*;

  logic [PhaseBits-1:0] ram_rdata;
  logic [PhaseBits-1:0] fwd_q;
  logic                 written_q;
  logic                 wrote_last_q;
  logic [PhaseBits-1:0] acc_cur;
  logic [PhaseBits-1:0] acc_base;
  logic [PhaseBits-1:0] acc_next;
  logic [PhaseBits-1:0] ph_total;
  logic [31:0]          turn;
  logic [31:0]          phase32;
  ph_t                  ph_q;

  mwsg_ram #(
    .Width (PhaseBits),
    .Depth (1)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (accept_i),
    .waddr_i (1'b0),
    .wdata_i (acc_next),
    .raddr_i (1'b0),
    .rdata_o (ram_rdata)
  );

  // Pick the live accumulator: zero before the first write, forward a fresh write
  always_comb begin
    if (!written_q) begin
      acc_cur = '0;
    end else if (wrote_last_q) begin
      acc_cur = fwd_q;
    end else begin
      acc_cur = ram_rdata;
    end
  end

  assign acc_base = restart_i ? '0 : acc_cur;
  assign ph_total = acc_base + PhaseBits'(phase_offset_i);
  assign acc_next = acc_base + PhaseBits'(frequency_step_i);

  // Bring the total phase to a 32-bit turn value
  generate
    if (PhaseBits >= 32) begin : g_wide
      assign turn    = ph_total[PhaseBits-1 -: 32];
      assign phase32 = ph_total[31:0];
    end else begin : g_narrow
      assign turn    = {ph_total, {(32 - PhaseBits){1'b0}}};
      assign phase32 = 32'(ph_total);
    end
  endgenerate

  // Track writes for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= 1'b0;
      wrote_last_q <= 1'b0;
    end else begin
      wrote_last_q <= accept_i;
      if (accept_i) begin
        written_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      fwd_q <= acc_next;
    end
  end

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0;
    end else if (en_i) begin
      ph_q.valid <= accept_i;
      ph_q.turn  <= turn;
      ph_q.phase <= phase32;
    end
  end

  assign ph_o = ph_q;

endmodule

`default_nettype wire

/* design/mwsg_shape.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shape stage
// Maps the turn value to a Q1.15 shape for sine, triangle and sawtooth.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsg_shape #(
  parameter int unsigned SineTableBits = mwsg_pkg::SINE_TABLE_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  mwsg_pkg::wave_e waveform_i,
  input  mwsg_pkg::ph_t   ph_i,
  output mwsg_pkg::sh_t   sh_o
);

  import mwsg_pkg::*;

  localparam int unsigned QuarterLen = 2 ** (SineTableBits - 2);

  logic [14:0]              sine_rom [QuarterLen + 1];
  logic [SineTableBits-1:0] idx;
  logic [1:0]               quad;
  logic [SineTableBits-2:0] j_ext;
  logic [SineTableBits-2:0] rom_addr;
  logic [14:0]              rom_val;
  logic signed [16:0]       sine_s;
  logic [31:0]              tri_dist;
  logic signed [17:0]       tri_raw;
  logic signed [16:0]       tri_s;
  logic signed [16:0]       saw_s;
  sh_t                      sh_d;
  sh_t                      sh_q;

  // Quarter-wave table, built at elaboration
  generate
    for (genvar k = 0; k <= QuarterLen; k++) begin : g_rom
      assign sine_rom[k] = sine_entry(k, SineTableBits);
    end
  endgenerate

  // Sine: mirror odd quadrants, negate the second half
  assign idx      = ph_i.turn[31 -: SineTableBits];
  assign quad     = idx[SineTableBits-1 -: 2];
  assign j_ext    = {1'b0, idx[SineTableBits-3:0]};
  assign rom_addr = quad[0] ? ((SineTableBits - 1)'(QuarterLen) - j_ext) : j_ext;
  assign rom_val  = sine_rom[rom_addr];
  assign sine_s   = quad[1] ? -$signed({2'b00, rom_val}) : $signed({2'b00, rom_val});

  // Triangle: distance from half a turn, clamp the peak
  assign tri_dist = ph_i.turn[31] ? (ph_i.turn - 32'h8000_0000)
                                  : (32'h8000_0000 - ph_i.turn);
  assign tri_raw  = $signed({1'b0, tri_dist[31:15]}) - 18'sd32768;
  assign tri_s    = (tri_raw > 18'sd32767) ? 17'sd32767 : tri_raw[16:0];

  // Sawtooth: fraction in Q15
  assign saw_s = $signed({2'b00, ph_i.turn[31:17]});

  always_comb begin
    sh_d          = '0;
    sh_d.valid    = ph_i.valid;
    sh_d.phase    = ph_i.phase;
    sh_d.negative = ph_i.turn[31];
    case (waveform_i)
      WAVE_SQUARE:   sh_d.square = 1'b1;
      WAVE_SINE:     sh_d.shape  = sine_s;
      WAVE_TRIANGLE: sh_d.shape  = tri_s;
      WAVE_SAWTOOTH: sh_d.shape  = saw_s;
      default:       sh_d.shape  = saw_s;
    endcase
  end

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q <= '0;
    end else if (en_i) begin
      sh_q <= sh_d;
    end
  end

  assign sh_o = sh_q;

endmodule

`default_nettype wire

/* design/mwsg_level.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level stages
// Scales the shape by the amplitude, adds the DC offset and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsg_level #(
  parameter int unsigned SampleBits = mwsg_pkg::SAMPLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [14:0]           amplitude_i,
  input  logic [15:0]           dc_offset_i,
  input  logic                  output_unsigned_i,
  input  mwsg_pkg::sh_t         sh_i,
  output logic                  valid_o,
  output logic [SampleBits-1:0] sample_o,
  output logic [31:0]           phase_o
);

  import mwsg_pkg::*;

  localparam int unsigned SumW = ((SampleBits > 17) ? SampleBits : 17) + 2;
  localparam logic signed [SumW-1:0] SMax = SumW'((64'd1 << (SampleBits - 1)) - 64'd1);
  localparam logic signed [SumW-1:0] SMin = -SMax - SumW'(1);

  logic signed [32:0]     prod;
  logic signed [32:0]     scaled;
  logic signed [17:0]     amp_s;
  logic signed [17:0]     lvl_d;
  logic signed [17:0]     lvl_q;
  logic                   lvl_valid_q;
  logic [31:0]            lvl_phase_q;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] sat;
  logic                   out_valid_q;
  logic [SampleBits-1:0]  sample_q;
  logic [31:0]            phase_q;

  // Scale with rounding; square passes the amplitude straight through
  assign prod   = $signed({1'b0, amplitude_i}) * sh_i.shape;
  assign scaled = (prod + 33'sd16384) >>> 15;
  assign amp_s  = $signed({3'b000, amplitude_i});
  always_comb begin
    if (sh_i.square) begin
      lvl_d = sh_i.negative ? -amp_s : amp_s;
    end else begin
      lvl_d = scaled[17:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_valid_q <= 1'b0;
    end else if (en_i) begin
      lvl_valid_q <= sh_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lvl_q       <= lvl_d;
      lvl_phase_q <= sh_i.phase;
    end
  end

  // Add DC offset and saturate
  assign sum = $signed({{(SumW - 18){lvl_q[17]}}, lvl_q})
             + $signed({{(SumW - 16){dc_offset_i[15]}}, dc_offset_i});

  always_comb begin
    sat = sum;
    if (output_unsigned_i) begin
      if (sum < 0) begin
        sat = '0;
      end
    end else if (sum < SMin) begin
      sat = SMin;
    end
    if (sum > SMax) begin
      sat = SMax;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= lvl_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sample_q <= sat[SampleBits-1:0];
      phase_q  <= lvl_phase_q;
    end
  end

  assign valid_o  = out_valid_q;
  assign sample_o = sample_q;
  assign phase_o  = phase_q;

endmodule

`default_nettype wire
